// File: src/bcii_pkg.sv
`default_nettype none

package bcii_pkg;

  localparam int unsigned CoordW   = 8;
  localparam int unsigned GridW    = 9;
  localparam int unsigned BlkW     = 13;
  localparam int unsigned OrgW     = 12;
  localparam int unsigned ExtW     = 20;
  localparam int unsigned LenW     = 13;
  localparam int unsigned ProdW    = GridW + BlkW;
  // walk positions: a block start may run one train width past the extent
  localparam int unsigned PosW     = ProdW + 1;
  localparam int unsigned CfgW     = 13;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned DivCntW  = $clog2(CoordW);
  localparam int unsigned BlkMax   = 4096;
  localparam int unsigned GridMax  = 256;

  typedef enum logic [CfgIdxW-1:0] {
    RegSrcBlockRows    = 3'd0,
    RegSrcBlockCols    = 3'd1,
    RegDstBlockRows    = 3'd2,
    RegDstBlockCols    = 3'd3,
    RegSrcFirstProcRow = 3'd4,
    RegSrcFirstProcCol = 3'd5,
    RegDstFirstProcRow = 3'd6,
    RegDstFirstProcCol = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic              use_rows;
    logic [GridW-1:0]  src_grid_width;
    logic [GridW-1:0]  dst_grid_width;
    logic [CoordW-1:0] src_proc_coord;
    logic [CoordW-1:0] dst_proc_coord;
    logic [OrgW-1:0]   src_origin;
    logic [OrgW-1:0]   dst_origin;
    logic [ExtW-1:0]   extent;
  } in_item_t;

  typedef struct packed {
    logic [ExtW-1:0] start_index;
    logic [LenW-1:0] length;
    logic            is_last;
    logic            is_empty;
    logic            truncated;
  } out_item_t;

  typedef struct packed {
    logic [BlkW-1:0]   src_block_rows;
    logic [BlkW-1:0]   src_block_cols;
    logic [BlkW-1:0]   dst_block_rows;
    logic [BlkW-1:0]   dst_block_cols;
    logic [CoordW-1:0] src_first_proc_row;
    logic [CoordW-1:0] src_first_proc_col;
    logic [CoordW-1:0] dst_first_proc_row;
    logic [CoordW-1:0] dst_first_proc_col;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic div_step;
    logic calc_shift;
    logic calc_mul;
    logic init_walk;
    logic walk_step;
    logic rd_issue;
    logic load_out;
    logic load_empty;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic walk_active;
    logic walk_run;
    logic walk_full;
    logic cnt_zero;
    logic rd_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: src/bcii_cfg.sv
`default_nettype none

module bcii_cfg
  import bcii_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i,
  output cfg_t                    cfg_o
);

  cfg_t     cfg_q, cfg_d;
  cfg_reg_e idx;

  assign idx = cfg_reg_e'(cfg_index_i);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (idx)
        RegSrcBlockRows:    cfg_d.src_block_rows     = cfg_wdata_i[BlkW-1:0];
        RegSrcBlockCols:    cfg_d.src_block_cols     = cfg_wdata_i[BlkW-1:0];
        RegDstBlockRows:    cfg_d.dst_block_rows     = cfg_wdata_i[BlkW-1:0];
        RegDstBlockCols:    cfg_d.dst_block_cols     = cfg_wdata_i[BlkW-1:0];
        RegSrcFirstProcRow: cfg_d.src_first_proc_row = cfg_wdata_i[CoordW-1:0];
        RegSrcFirstProcCol: cfg_d.src_first_proc_col = cfg_wdata_i[CoordW-1:0];
        RegDstFirstProcRow: cfg_d.dst_first_proc_row = cfg_wdata_i[CoordW-1:0];
        RegDstFirstProcCol: cfg_d.dst_first_proc_col = cfg_wdata_i[CoordW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_block_rows     <= BlkW'(1);
      cfg_q.src_block_cols     <= BlkW'(1);
      cfg_q.dst_block_rows     <= BlkW'(1);
      cfg_q.dst_block_cols     <= BlkW'(1);
      cfg_q.src_first_proc_row <= '0;
      cfg_q.src_first_proc_col <= '0;
      cfg_q.dst_first_proc_row <= '0;
      cfg_q.dst_first_proc_col <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: src/bcii_ctrl.sv
`default_nettype none

module bcii_ctrl
  import bcii_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StDiv   = 9'b000000010,
    StShift = 9'b000000100,
    StMul   = 9'b000001000,
    StInit  = 9'b000010000,
    StWalk  = 9'b000100000,
    StEmpty = 9'b001000000,
    StRead  = 9'b010000000,
    StLoad  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = StShift;
      end
      StShift: begin
        cmd_o.calc_shift = 1'b1;
        state_d          = StMul;
      end
      StMul: begin
        cmd_o.calc_mul = 1'b1;
        state_d        = StInit;
      end
      StInit: begin
        cmd_o.init_walk = 1'b1;
        state_d         = StWalk;
      end
      StWalk: begin
        cmd_o.walk_step = 1'b1;
        // a run found with the buffer full only marks truncation and ends the walk
        if (!sts_i.walk_active || (sts_i.walk_run && sts_i.walk_full)) begin
          state_d = sts_i.cnt_zero ? StEmpty : StRead;
        end
      end
      StEmpty: begin
        if (sts_i.out_free) begin
          cmd_o.load_empty = 1'b1;
          state_d          = StIdle;
        end
      end
      StRead: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = StLoad;
      end
      StLoad: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = sts_i.rd_last ? StIdle : StRead;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);

endmodule

`default_nettype wire

// File: src/bcii_dp.sv
`default_nettype none

module bcii_dp
  import bcii_pkg::*;
#(
  parameter int unsigned MAX_RUN = 64
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire in_item_t in_data_i,
  input  wire cfg_t     cfg_i,
  input  wire cmd_t     cmd_i,
  output sts_t          sts_o,
  output logic          out_valid_o,
  output out_item_t     out_data_o,
  input  wire logic     out_stall_i
);

  localparam int unsigned CntW = $clog2(MAX_RUN + 1);
  localparam int unsigned IdxW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

  typedef struct packed {
    logic [ExtW-1:0] start;
    logic [LenW-1:0] len;
  } run_t;

  function automatic logic [BlkW-1:0] clamp_blk(logic [BlkW-1:0] v);
    logic [BlkW-1:0] r;
    r = v;
    if (v == '0) r = BlkW'(1);
    else if (v > BlkW'(BlkMax)) r = BlkW'(BlkMax);
    return r;
  endfunction

  function automatic logic [GridW-1:0] clamp_grid(logic [GridW-1:0] v);
    logic [GridW-1:0] r;
    r = v;
    if (v == '0) r = GridW'(1);
    else if (v > GridW'(GridMax)) r = GridW'(GridMax);
    return r;
  endfunction

  // one restoring step of the remainder; r stays below d
  function automatic logic [GridW-1:0] rem_step(logic [GridW-1:0] r, logic b,
                                                logic [GridW-1:0] d);
    logic [GridW:0] t;
    logic [GridW:0] u;
    t = {r, b};
    u = t - {1'b0, d};
    if (t >= {1'b0, d}) return u[GridW-1:0];
    return t[GridW-1:0];
  endfunction

  function automatic logic [GridW-1:0] shift_of(logic [GridW-1:0] rc,
                                                logic [GridW-1:0] rf,
                                                logic [GridW-1:0] q);
    logic [GridW:0] t;
    if (rc >= rf) t = {1'b0, rc} - {1'b0, rf};
    else t = {1'b0, rc} + {1'b0, q} - {1'b0, rf};
    return t[GridW-1:0];
  endfunction

  // setup registers
  logic [GridW-1:0]  q0_q, q0_d, q1_q, q1_d;
  logic [BlkW-1:0]   nb0_q, nb0_d, nb1_q, nb1_d;
  logic [OrgW-1:0]   org0_q, org0_d, org1_q, org1_d;
  logic [ExtW-1:0]   n_q, n_d;
  logic [CoordW-1:0] dvd_q [4];
  logic [CoordW-1:0] dvd_d [4];
  logic [GridW-1:0]  rem_q [4];
  logic [GridW-1:0]  rem_d [4];
  logic [DivCntW-1:0] div_ctr_q, div_ctr_d;
  logic [GridW-1:0]  sh0_q, sh0_d, sh1_q, sh1_d;
  logic [ProdW-1:0]  prod0_q, prod0_d, prod1_q, prod1_d;
  logic [ProdW-1:0]  tw0_q, tw0_d, tw1_q, tw1_d;

  // walk registers
  logic signed [PosW-1:0] j0_q, j0_d, e0_q, e0_d, j1_q, j1_d, e1_q, e1_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            trunc_q, trunc_d;
  logic [CntW-1:0] rd_ptr_q, rd_ptr_d;

  // result buffer
  run_t            mem_q [MAX_RUN];
  run_t            rd_data_q;
  logic            mem_we;
  run_t            mem_wdata;

  out_item_t       out_q, out_d;
  logic            out_valid_q, out_valid_d;

  // walk datapath
  logic signed [PosW-1:0] n_s, tw0_s, tw1_s, j0_init, j1_init;
  logic signed [PosW-1:0] s_raw, s_c, e_min, e_c, len_w;
  logic active, skip0, skip1, ovl, adv0, adv1, run, full, rd_last, out_free;

  assign n_s     = $signed(PosW'(n_q));
  assign tw0_s   = $signed(PosW'(tw0_q));
  assign tw1_s   = $signed(PosW'(tw1_q));
  assign j0_init = $signed(PosW'(prod0_q)) - $signed(PosW'(org0_q));
  assign j1_init = $signed(PosW'(prod1_q)) - $signed(PosW'(org1_q));

  assign active = (j0_q < n_s) && (j1_q < n_s);
  assign skip0  = (e0_q <= j1_q);
  assign skip1  = !skip0 && (e1_q <= j0_q);
  assign ovl    = !skip0 && !skip1;
  assign s_raw  = (j0_q > j1_q) ? j0_q : j1_q;
  assign s_c    = s_raw[PosW-1] ? '0 : s_raw;
  assign e_min  = (e0_q < e1_q) ? e0_q : e1_q;
  assign e_c    = (e_min > n_s) ? n_s : e_min;
  assign adv0   = skip0 || (ovl && (e0_q == e_min));
  assign adv1   = skip1 || (ovl && (e1_q == e_min));
  assign run    = ovl && (e_c > s_c);
  assign len_w  = e_c - s_c;
  assign full   = (cnt_q == CntW'(MAX_RUN));
  assign rd_last  = ((rd_ptr_q + CntW'(1)) == cnt_q);
  assign out_free = !out_valid_q || !out_stall_i;

  assign mem_we    = cmd_i.walk_step && active && run && !full;
  assign mem_wdata = '{start: s_c[ExtW-1:0], len: len_w[LenW-1:0]};

  always_comb begin
    q0_d      = q0_q;
    q1_d      = q1_q;
    nb0_d     = nb0_q;
    nb1_d     = nb1_q;
    org0_d    = org0_q;
    org1_d    = org1_q;
    n_d       = n_q;
    dvd_d     = dvd_q;
    rem_d     = rem_q;
    div_ctr_d = div_ctr_q;
    sh0_d     = sh0_q;
    sh1_d     = sh1_q;
    prod0_d   = prod0_q;
    prod1_d   = prod1_q;
    tw0_d     = tw0_q;
    tw1_d     = tw1_q;
    j0_d      = j0_q;
    e0_d      = e0_q;
    j1_d      = j1_q;
    e1_d      = e1_q;
    cnt_d     = cnt_q;
    trunc_d   = trunc_q;
    rd_ptr_d  = rd_ptr_q;

    if (cmd_i.capture) begin
      q0_d   = clamp_grid(in_data_i.src_grid_width);
      q1_d   = clamp_grid(in_data_i.dst_grid_width);
      nb0_d  = clamp_blk(in_data_i.use_rows ? cfg_i.src_block_rows : cfg_i.src_block_cols);
      nb1_d  = clamp_blk(in_data_i.use_rows ? cfg_i.dst_block_rows : cfg_i.dst_block_cols);
      org0_d = in_data_i.src_origin;
      org1_d = in_data_i.dst_origin;
      n_d    = in_data_i.extent;
      dvd_d[0] = in_data_i.src_proc_coord;
      dvd_d[1] = in_data_i.use_rows ? cfg_i.src_first_proc_row : cfg_i.src_first_proc_col;
      dvd_d[2] = in_data_i.dst_proc_coord;
      dvd_d[3] = in_data_i.use_rows ? cfg_i.dst_first_proc_row : cfg_i.dst_first_proc_col;
      for (int i = 0; i < 4; i++) rem_d[i] = '0;
      div_ctr_d = '0;
    end

    if (cmd_i.div_step) begin
      for (int i = 0; i < 4; i++) begin
        rem_d[i] = rem_step(rem_q[i], dvd_q[i][CoordW-1], (i < 2) ? q0_q : q1_q);
        dvd_d[i] = {dvd_q[i][CoordW-2:0], 1'b0};
      end
      div_ctr_d = div_ctr_q + DivCntW'(1);
    end

    if (cmd_i.calc_shift) begin
      sh0_d = shift_of(rem_q[0], rem_q[1], q0_q);
      sh1_d = shift_of(rem_q[2], rem_q[3], q1_q);
    end

    if (cmd_i.calc_mul) begin
      prod0_d = ProdW'(sh0_q) * ProdW'(nb0_q);
      prod1_d = ProdW'(sh1_q) * ProdW'(nb1_q);
      tw0_d   = ProdW'(q0_q) * ProdW'(nb0_q);
      tw1_d   = ProdW'(q1_q) * ProdW'(nb1_q);
    end

    if (cmd_i.init_walk) begin
      j0_d     = j0_init;
      e0_d     = j0_init + $signed(PosW'(nb0_q));
      j1_d     = j1_init;
      e1_d     = j1_init + $signed(PosW'(nb1_q));
      cnt_d    = '0;
      trunc_d  = 1'b0;
      rd_ptr_d = '0;
    end

    if (cmd_i.walk_step && active) begin
      if (adv0) begin
        j0_d = j0_q + tw0_s;
        e0_d = e0_q + tw0_s;
      end
      if (adv1) begin
        j1_d = j1_q + tw1_s;
        e1_d = e1_q + tw1_s;
      end
      if (run) begin
        if (full) trunc_d = 1'b1;
        else cnt_d = cnt_q + CntW'(1);
      end
    end

    if (cmd_i.load_out) rd_ptr_d = rd_ptr_q + CntW'(1);
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (!out_stall_i) out_valid_d = 1'b0;
    if (cmd_i.load_out) begin
      out_d.start_index = rd_data_q.start;
      out_d.length      = rd_data_q.len;
      out_d.is_last     = rd_last;
      out_d.is_empty    = 1'b0;
      out_d.truncated   = trunc_q;
      out_valid_d       = 1'b1;
    end else if (cmd_i.load_empty) begin
      out_d.start_index = '0;
      out_d.length      = '0;
      out_d.is_last     = 1'b1;
      out_d.is_empty    = 1'b1;
      out_d.truncated   = 1'b0;
      out_valid_d       = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_ctr_q   <= '0;
      cnt_q       <= '0;
      trunc_q     <= 1'b0;
      rd_ptr_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      div_ctr_q   <= div_ctr_d;
      cnt_q       <= cnt_d;
      trunc_q     <= trunc_d;
      rd_ptr_q    <= rd_ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q0_q    <= q0_d;
    q1_q    <= q1_d;
    nb0_q   <= nb0_d;
    nb1_q   <= nb1_d;
    org0_q  <= org0_d;
    org1_q  <= org1_d;
    n_q     <= n_d;
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
    sh0_q   <= sh0_d;
    sh1_q   <= sh1_d;
    prod0_q <= prod0_d;
    prod1_q <= prod1_d;
    tw0_q   <= tw0_d;
    tw1_q   <= tw1_d;
    j0_q    <= j0_d;
    e0_q    <= e0_d;
    j1_q    <= j1_d;
    e1_q    <= e1_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[cnt_q[IdxW-1:0]] <= mem_wdata;
    if (cmd_i.rd_issue) rd_data_q <= mem_q[rd_ptr_q[IdxW-1:0]];
  end

  assign sts_o.div_last    = (div_ctr_q == '1);
  assign sts_o.walk_active = active;
  assign sts_o.walk_run    = run;
  assign sts_o.walk_full   = full;
  assign sts_o.cnt_zero    = (cnt_q == '0);
  assign sts_o.rd_last     = rd_last;
  assign sts_o.out_free    = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_RUN))
    else $error("run count beyond buffer depth");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_out || cmd_i.load_empty) |-> out_free)
    else $error("output register overwritten while held");

  a_trunc_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trunc_q |-> full)
    else $error("truncation flagged with buffer not full");
`endif

endmodule

`default_nettype wire

// File: src/block_cyclic_interval_intersect_core.sv
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    in_data_i  (in_item_t)
// out      output     out_valid_o / out_stall_i  out_data_o (out_item_t)
// cfg      input      cfg_we_i                   cfg_index_i, cfg_wdata_i
//
// One request at a time: accept, remainder division (one bit a cycle), the setup
// states shift, multiply and walk init, then the block walk at one merge step a
// cycle (skips and overlaps alike), then each result is read out of the buffer.
// The walk length follows extent over the smaller train step and sets the total.
// Reset is asynchronous; config resets to block size 1 and first process 0.
// A stalled output holds the block; in_stall_o is high from accept to last load.
`default_nettype none

module block_cyclic_interval_intersect_core
  import bcii_pkg::*;
#(
  parameter int unsigned MAX_RUN = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire in_item_t           in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output out_item_t               out_data_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  bcii_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  bcii_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  bcii_dp #(
    .MAX_RUN(MAX_RUN)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_stall_i(out_stall_i)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second request taken while busy");

  a_empty_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.is_empty) |->
      (out_data_o.is_last && out_data_o.length == '0 && !out_data_o.truncated))
    else $error("empty marker malformed");

  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.is_empty) |-> (out_data_o.length != '0))
    else $error("zero-length overlap transferred");
`endif

endmodule

`default_nettype wire
